FILE: rtl/smh64_pkg.sv
// ----------------------------------------------------------------------------
// smh64_pkg
// Types, constants and arithmetic helpers of the short message hash pipeline.
// ----------------------------------------------------------------------------
package smh64_pkg;

    localparam logic [63:0] HK0 = 64'hc3a5c85c97cb3127;
    localparam logic [63:0] HK2 = 64'h9ae16a3b2f90404f;

    typedef enum logic [1:0] {
        MODE_LEN1TO3  = 2'd0,
        MODE_LEN4TO7  = 2'd1,
        MODE_LEN8UP   = 2'd2,
        MODE_LEN33UP  = 2'd3
    } t_mode;

    // partial products of a 64x64 low-half multiply
    typedef struct packed {
        logic [63:0] lo;
        logic [31:0] m1;
        logic [31:0] m2;
    } t_pp;

    typedef struct packed {
        t_mode       mode;
        logic        ok;
        logic [63:0] mul;
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
        logic [63:0] v4;
        logic [63:0] v5;
        logic [63:0] v6;
        logic [63:0] v7;
        logic [63:0] v8;
        logic [63:0] hv;
        t_pp         pp0;
        t_pp         pp1;
        t_pp         pp2;
    } t_st;

    function automatic t_pp mul_parts(input logic [63:0] a, input logic [63:0] b);
        t_pp         p;
        logic [63:0] t1;
        logic [63:0] t2;
        p.lo = a[31:0] * b[31:0];
        t1   = a[31:0] * b[63:32];
        t2   = a[63:32] * b[31:0];
        p.m1 = t1[31:0];
        p.m2 = t2[31:0];
        return p;
    endfunction

    function automatic logic [63:0] mul_sum(input t_pp p);
        logic [31:0] m;
        m = p.m1 + p.m2;
        return p.lo + {m, 32'h0};
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] v, input logic [5:0] s);
        logic [127:0] t;
        t = {v, v} >> s;
        return t[63:0];
    endfunction

    function automatic logic [63:0] smix(input logic [63:0] v);
        return v ^ (v >> 47);
    endfunction

    function automatic logic [63:0] bswap(input logic [63:0] x);
        logic [63:0] r;
        for (int k = 0; k < 8; k++) begin
            r[8*k +: 8] = x[56-8*k +: 8];
        end
        return r;
    endfunction

    function automatic logic [63:0] mul9(input logic [63:0] v);
        return (v << 3) + v;
    endfunction

endpackage

FILE: rtl/short_message_hash64_unit.sv
// ----------------------------------------------------------------------------
// short_message_hash64_unit
// Pipelined 64-bit hash of messages up to 64 bytes, four length paths.
// ----------------------------------------------------------------------------
// A request carries mode, length and eight little-endian message words on
// i_valid / o_ready; the result (o_hash, o_valid_res) leaves on o_valid /
// i_ready. The mode picks the path: short (1..3), medium (4..7), long (8..64)
// or wide (33..64 bytes). A length outside the path's range returns hash 0
// with o_valid_res low.
// One request enters per cycle while o_ready is high.
// The depth is set by the longest path, a chain of dependent 64x64
// multiplies, each split into a partial-product stage and a sum stage.
// Each stage holds its own valid bit and advances when the stage behind it
// is empty or advancing, so a stalled receiver holds the results in place and
// empty stages still fill; o_ready drops only once the pipeline is full.
// Reset clears all valid bits; no request is in flight afterwards.
// ----------------------------------------------------------------------------
module short_message_hash64_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [6:0]  i_length,
    input  logic [63:0] i_word0,
    input  logic [63:0] i_word1,
    input  logic [63:0] i_word2,
    input  logic [63:0] i_word3,
    input  logic [63:0] i_word4,
    input  logic [63:0] i_word5,
    input  logic [63:0] i_word6,
    input  logic [63:0] i_word7,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_hash,
    output logic        o_valid_res
);
    import smh64_pkg::*;

    localparam int NS = 16;

    t_st          r_st  [NS];
    logic [NS-1:0] r_vld;
    t_st          n_st  [NS];
    t_st          n_st0;
    logic [NS:0]  en;

    logic [511:0] img;
    logic [6:0]   off_g;
    logic [6:0]   off_c;
    logic [6:0]   off_d;
    logic [6:0]   off_h;
    logic [6:0]   off_4;
    logic [6:0]   off_1;
    logic [63:0]  sh4;
    logic [63:0]  shb;
    logic [63:0]  shc;
    logic [15:0]  y0;
    logic [31:0]  z0;

    function automatic logic [63:0] ld64(input logic [511:0] m, input logic [5:0] off);
        logic [1023:0] t;
        t = {m, m} >> {off, 3'b000};
        return t[63:0];
    endfunction

    function automatic t_st step(input int k, input t_st s);
        t_st n;
        n = s;
        case (k)
            1: begin
                case (s.mode)
                    MODE_LEN33UP: begin
                        n.pp0 = mul_parts(s.v0, HK2);
                        n.pp1 = mul_parts(s.v2, HK2);
                        n.pp2 = mul_parts(s.v7, s.mul);
                        n.v3  = mul9(s.v3);
                    end
                    MODE_LEN8UP: begin
                        n.pp0 = mul_parts(rotr(s.v4, 6'd37), s.mul);
                        n.pp1 = mul_parts(rotr(s.v0, 6'd25) + s.v4, s.mul);
                    end
                    MODE_LEN4TO7: n.pp0 = mul_parts(s.v0 ^ s.v1, s.mul);
                    default: begin
                        n.pp0 = mul_parts(s.v0, HK2);
                        n.pp1 = mul_parts(s.v1, HK0);
                    end
                endcase
            end
            2: begin
                case (s.mode)
                    MODE_LEN33UP: begin
                        n.v0 = mul_sum(s.pp0);
                        n.v2 = mul_sum(s.pp1);
                        n.v7 = mul_sum(s.pp2);
                    end
                    MODE_LEN8UP: begin
                        n.v0 = mul_sum(s.pp0) + s.v0;
                        n.v1 = mul_sum(s.pp1);
                    end
                    MODE_LEN4TO7: n.v2 = smix(mul_sum(s.pp0));
                    default:      n.v2 = smix(mul_sum(s.pp0) ^ mul_sum(s.pp1));
                endcase
            end
            3: begin
                case (s.mode)
                    MODE_LEN33UP: begin
                        n.v0 = s.v0 + s.v4;
                        n.v1 = rotr(s.v8, 6'd30) + s.v5;
                        n.v2 = s.v2 + s.v3;
                    end
                    MODE_LEN8UP:  n.pp0 = mul_parts(s.v0 ^ s.v1, s.mul);
                    MODE_LEN4TO7: n.pp0 = mul_parts(s.v1 ^ s.v2, s.mul);
                    default:      n.pp0 = mul_parts(s.v2, HK2);
                endcase
            end
            4: begin
                case (s.mode)
                    MODE_LEN33UP: begin
                        n.v1 = rotr(s.v0, 6'd43) + mul9(s.v1);
                        n.v0 = (s.v0 ^ s.v6) + s.v3 + 64'd1;
                        n.v2 = rotr(s.v2, 6'd42) + s.v5;
                        n.v3 = s.v2 + s.v5;
                    end
                    MODE_LEN8UP:  n.v2 = smix(mul_sum(s.pp0));
                    MODE_LEN4TO7: n.v2 = smix(mul_sum(s.pp0));
                    default:      n.hv = mul_sum(s.pp0);
                endcase
            end
            5: begin
                case (s.mode)
                    MODE_LEN33UP: begin
                        n.pp0 = mul_parts(s.v1 + s.v0, s.mul);
                        n.pp1 = mul_parts(s.v2 + s.v3, s.mul);
                    end
                    MODE_LEN8UP:  n.pp0 = mul_parts(s.v1 ^ s.v2, s.mul);
                    MODE_LEN4TO7: n.pp0 = mul_parts(s.v2, s.mul);
                    default:      n = s;
                endcase
            end
            6: begin
                case (s.mode)
                    MODE_LEN33UP: begin
                        n.v1 = bswap(mul_sum(s.pp0)) + s.v7;
                        n.v5 = mul_sum(s.pp1);
                    end
                    MODE_LEN8UP:  n.v2 = smix(mul_sum(s.pp0));
                    MODE_LEN4TO7: n.hv = mul_sum(s.pp0);
                    default:      n = s;
                endcase
            end
            7: begin
                case (s.mode)
                    MODE_LEN33UP: n.pp0 = mul_parts(s.v0 + s.v1, s.mul);
                    MODE_LEN8UP:  n.pp0 = mul_parts(s.v2, s.mul);
                    default:      n = s;
                endcase
            end
            8: begin
                case (s.mode)
                    MODE_LEN33UP: n.v1 = bswap(mul_sum(s.pp0)) + s.v4;
                    MODE_LEN8UP:  n.hv = mul_sum(s.pp0);
                    default:      n = s;
                endcase
            end
            9: begin
                if (s.mode == MODE_LEN33UP) begin
                    n.pp0 = mul_parts(s.v1, s.mul);
                end
            end
            10: begin
                if (s.mode == MODE_LEN33UP) begin
                    n.v1 = mul_sum(s.pp0);
                end
            end
            11: begin
                if (s.mode == MODE_LEN33UP) begin
                    n.v0 = bswap(s.v5 + s.v1) + s.v8;
                end
            end
            12: begin
                if (s.mode == MODE_LEN33UP) begin
                    n.pp0 = mul_parts(s.v3 + s.v0, s.mul);
                end
            end
            13: begin
                if (s.mode == MODE_LEN33UP) begin
                    n.v0 = mul_sum(s.pp0) + s.v6 + s.v7;
                end
            end
            14: begin
                if (s.mode == MODE_LEN33UP) begin
                    n.pp0 = mul_parts(smix(s.v0), s.mul);
                end
            end
            15: begin
                if (s.mode == MODE_LEN33UP) begin
                    n.hv = mul_sum(s.pp0) + s.v2;
                end
            end
            default: n = s;
        endcase
        return n;
    endfunction

    assign img   = {i_word7, i_word6, i_word5, i_word4, i_word3, i_word2, i_word1, i_word0};
    assign off_g = i_length - 7'd8;
    assign off_c = i_length - 7'd24;
    assign off_d = i_length - 7'd32;
    assign off_h = i_length - 7'd16;
    assign off_4 = i_length - 7'd4;
    assign off_1 = i_length - 7'd1;
    assign sh4   = i_word0 >> {off_4[1:0], 3'b000};
    assign shb   = i_word0 >> {i_length[2:1], 3'b000};
    assign shc   = i_word0 >> {off_1[1:0], 3'b000};
    assign y0    = {shb[7:0], 8'h00} + {8'h00, i_word0[7:0]};
    assign z0    = {25'd0, i_length} + {22'd0, shc[7:0], 2'b00};

    always_comb begin
        n_st0      = '0;
        n_st0.mode = t_mode'(i_mode);
        n_st0.mul  = HK2 + {56'd0, i_length, 1'b0};
        case (t_mode'(i_mode))
            MODE_LEN33UP: begin
                n_st0.ok = (i_length >= 7'd33) && (i_length <= 7'd64);
                n_st0.v0 = i_word0;
                n_st0.v8 = i_word1;
                n_st0.v2 = i_word2;
                n_st0.v3 = i_word3;
                n_st0.v4 = ld64(img, off_g[5:0]);
                n_st0.v5 = ld64(img, off_c[5:0]);
                n_st0.v6 = ld64(img, off_d[5:0]);
                n_st0.v7 = ld64(img, off_h[5:0]);
            end
            MODE_LEN8UP: begin
                n_st0.ok = (i_length >= 7'd8) && (i_length <= 7'd64);
                n_st0.v0 = i_word0 + HK2;
                n_st0.v4 = ld64(img, off_g[5:0]);
            end
            MODE_LEN4TO7: begin
                n_st0.ok = (i_length >= 7'd4) && (i_length <= 7'd7);
                n_st0.v0 = {57'd0, i_length} + {29'd0, i_word0[31:0], 3'b000};
                n_st0.v1 = {32'd0, sh4[31:0]};
            end
            default: begin
                n_st0.ok = (i_length >= 7'd1) && (i_length <= 7'd3);
                n_st0.v0 = {48'd0, y0};
                n_st0.v1 = {32'd0, z0};
            end
        endcase
    end

    assign n_st[0] = n_st0;

    for (genvar k = 1; k < NS; k++) begin : g_step
        assign n_st[k] = step(k, r_st[k-1]);
    end

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_ready     = en[0];
    assign o_valid     = r_vld[NS-1];
    assign o_valid_res = r_st[NS-1].ok;
    assign o_hash      = r_st[NS-1].ok ? r_st[NS-1].hv : 64'd0;

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// short_message_hash64_unit testbench
// Sends mode/length/message requests over valid/ready, predicts each hash
// with an independent model of the four length paths and checks every result
// in order. Covers range edges, all modes, random content, random idling on
// both sides and a long receiver hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import smh64_pkg::*;

    localparam logic [63:0] K0 = 64'hc3a5c85c97cb3127;
    localparam logic [63:0] K2 = 64'h9ae16a3b2f90404f;

    typedef struct {
        logic [63:0] hash;
        logic        ok;
    } t_hash_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode = '0;
    logic [6:0]  i_length = '0;
    logic [63:0] i_word0 = '0, i_word1 = '0, i_word2 = '0, i_word3 = '0;
    logic [63:0] i_word4 = '0, i_word5 = '0, i_word6 = '0, i_word7 = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_hash;
    logic        o_valid_res;

    t_hash_res   hash_fifo[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cycles = 0;
    int          mismatches = 0;
    logic [7:0]  msg_img[64];

    short_message_hash64_unit i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [63:0] ld(input int off, input int nb);
        logic [63:0] r;
        r = '0;
        for (int k = 0; k < nb; k++) r[8*k +: 8] = msg_img[(off + k) & 63];
        return r;
    endfunction

    function automatic logic [63:0] ror(input logic [63:0] v, input int s);
        return (s == 0) ? v : ((v >> s) | (v << (64 - s)));
    endfunction

    function automatic logic [63:0] sh47(input logic [63:0] v);
        return v ^ (v >> 47);
    endfunction

    function automatic logic [63:0] flip(input logic [63:0] x);
        logic [63:0] r;
        for (int k = 0; k < 8; k++) r[8*k +: 8] = x[8*(7-k) +: 8];
        return r;
    endfunction

    function automatic logic [63:0] hmix(input logic [63:0] u, v, m);
        logic [63:0] a, b;
        a = (u ^ v) * m;
        a = sh47(a);
        b = (v ^ a) * m;
        b = sh47(b);
        return b * m;
    endfunction

    function automatic t_hash_res hash_short(input logic [1:0] md, input int len,
                                             input logic [63:0] w[8]);
        t_hash_res   r;
        logic [63:0] m, a, b, c, d, e, f, g, h, u, v, x, y, z, ww;
        for (int i = 0; i < 64; i++) msg_img[i] = w[i/8][8*(i%8) +: 8];
        m = K2 + 64'(len) * 2;
        r.hash = '0;
        r.ok = 1'b0;
        case (t_mode'(md))
            MODE_LEN1TO3: if (len >= 1 && len <= 3) begin
                r.ok = 1'b1;
                y = (ld(0, 1) + (ld(len >> 1, 1) << 8)) & 64'hffffffff;
                z = (64'(len) + (ld(len - 1, 1) << 2)) & 64'hffffffff;
                r.hash = sh47((y * K2) ^ (z * K0)) * K2;
            end
            MODE_LEN4TO7: if (len >= 4 && len <= 7) begin
                r.ok = 1'b1;
                r.hash = hmix(64'(len) + (ld(0, 4) << 3), ld(len - 4, 4), m);
            end
            MODE_LEN8UP: if (len >= 8 && len <= 64) begin
                r.ok = 1'b1;
                a = ld(0, 8) + K2;
                b = ld(len - 8, 8);
                c = ror(b, 37) * m + a;
                d = (ror(a, 25) + b) * m;
                r.hash = hmix(c, d, m);
            end
            default: if (len >= 33 && len <= 64) begin
                r.ok = 1'b1;
                a = ld(0, 8) * K2;
                b = ld(8, 8);
                e = ld(16, 8) * K2;
                f = ld(24, 8) * 9;
                g = ld(len - 8, 8);
                c = ld(len - 24, 8);
                d = ld(len - 32, 8);
                h = ld(len - 16, 8) * m;
                u = ror(a + g, 43) + (ror(b, 30) + c) * 9;
                v = ((a + g) ^ d) + f + 1;
                ww = flip((u + v) * m) + h;
                y = (flip((v + ww) * m) + g) * m;
                x = ror(e + f, 42) + c;
                z = e + f + c;
                a = flip((x + z) * m + y) + b;
                b = sh47((z + a) * m + d + h) * m;
                r.hash = b + x;
            end
        endcase
        return r;
    endfunction

    task automatic send_request(input logic [1:0] md, input int len, input logic [63:0] w[8]);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_mode   <= md;
        i_length <= 7'(len);
        {i_word7, i_word6, i_word5, i_word4, i_word3, i_word2, i_word1, i_word0}
            <= {w[7], w[6], w[5], w[4], w[3], w[2], w[1], w[0]};
        do @(posedge i_clk); while (!o_ready);
        hash_fifo.push_back(hash_short(md, len, w));
    endtask

    task automatic rand_words(output logic [63:0] w[8]);
        for (int k = 0; k < 8; k++) w[k] = {$urandom, $urandom};
    endtask

    task automatic drain();
        int n;
        n = 0;
        i_valid <= 1'b0;
        while (hash_fifo.size() != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    task automatic test_edges();
        logic [63:0] w[8];
        int lens[] = '{0, 1, 3, 4, 7, 8, 32, 33, 64, 65, 127};
        for (int k = 0; k < 8; k++) w[k] = '1;
        send_request(MODE_LEN8UP, 64, w);
        for (int k = 0; k < 8; k++) w[k] = '0;
        send_request(MODE_LEN33UP, 33, w);
        for (int md = 0; md < 4; md++) begin
            foreach (lens[i]) begin
                if ((i + md) % 2 == 0) begin
                    rand_words(w);
                    send_request(md[1:0], lens[i], w);
                end
            end
        end
        drain();
    endtask

    task automatic test_random(input int count);
        logic [63:0] w[8];
        int md, len;
        for (int n = 0; n < count; n++) begin
            md = $urandom_range(3);
            rand_words(w);
            if ($urandom_range(9) == 0) len = $urandom_range(127);
            else case (md)
                0: len = $urandom_range(3, 1);
                1: len = $urandom_range(7, 4);
                2: len = $urandom_range(64, 8);
                default: len = $urandom_range(64, 33);
            endcase
            send_request(md[1:0], len, w);
        end
        drain();
    endtask

    task automatic test_backpressure();
        logic [63:0] w[8];
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 60;
        for (int n = 0; n < 40; n++) begin
            rand_words(w);
            send_request(MODE_LEN33UP, $urandom_range(64, 33), w);
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_ready <= !($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_hash_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (hash_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result hash=%h", o_hash);
            end else begin
                e = hash_fifo.pop_front();
                if (o_hash !== e.hash || o_valid_res !== e.ok) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp hash=%h ok=%b got hash=%h ok=%b",
                                 e.hash, e.ok, o_hash, o_valid_res);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edges();
        send_idle_pct = 7;
        recv_idle_pct = 52;
        test_random(400);
        send_idle_pct = 52;
        recv_idle_pct = 7;
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(400);
        test_backpressure();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && hash_fifo.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
